FILE: rtl/bgma_pkg.sv
package bgma_pkg;

  localparam int unsigned SAMPLE_W   = 12;
  localparam int unsigned MV_W       = 13;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned MV_NUM_W   = 22;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CURVE_PTS  = 12;
  localparam int unsigned SEG_DM_W   = 8;
  localparam int unsigned SEG_DP_W   = 4;
  localparam int unsigned SEG_NUM_W  = SEG_DM_W + SEG_DP_W;

  localparam logic [SAMPLE_W-1:0] RAW_EMPTY_RST = 12'd2050;
  localparam logic [SAMPLE_W-1:0] RAW_FULL_RST  = 12'd2450;

  localparam logic [MV_W-1:0] MV_EMPTY = 13'd3300;
  localparam logic [MV_W-1:0] MV_FULL  = 13'd4200;
  localparam logic [9:0]      MV_SPAN  = 10'd900;
  localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

  localparam logic [MV_W-1:0] CURVE_MV [CURVE_PTS] = '{
    13'd3300, 13'd3450, 13'd3550, 13'd3650, 13'd3700, 13'd3750,
    13'd3800, 13'd3850, 13'd3920, 13'd4000, 13'd4100, 13'd4200
  };
  localparam logic [PCT_W-1:0] CURVE_PCT [CURVE_PTS] = '{
    7'd0, 7'd5, 7'd10, 7'd20, 7'd30, 7'd40,
    7'd50, 7'd60, 7'd70, 7'd82, 7'd92, 7'd100
  };

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RAW_EMPTY    = 2'd0,
    CFG_RAW_FULL     = 2'd1,
    CFG_CHARGE_SENSE = 2'd2
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SUM,
    ST_AVG_START,
    ST_AVG_WAIT,
    ST_MV_MAP,
    ST_MV_START,
    ST_MV_WAIT,
    ST_PCT_MAP,
    ST_PCT_START,
    ST_PCT_WAIT,
    ST_OUT
  } back_state_e;

  typedef struct packed {
    logic [SAMPLE_W-1:0] adc_sample;
    logic                charge_pin_level;
  } in_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] average_raw;
    logic [MV_W-1:0]     battery_millivolts;
    logic [PCT_W-1:0]    charge_percent;
    logic                is_charging;
  } out_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] raw_empty;
    logic [SAMPLE_W-1:0] raw_full;
    logic                charge_sense_present;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                charging;
  } job_t;

  typedef struct packed {
    logic [MV_W-1:0]     m0;
    logic [SEG_DM_W-1:0] dm;
    logic [PCT_W-1:0]    p0;
    logic [SEG_DP_W-1:0] dp;
  } seg_t;

  // Picks the first curve segment whose upper voltage is at or above mv.
  function automatic seg_t curve_segment(input logic [MV_W-1:0] mv);
    seg_t s;
    s.m0 = CURVE_MV[0];
    s.dm = SEG_DM_W'(CURVE_MV[1] - CURVE_MV[0]);
    s.p0 = CURVE_PCT[0];
    s.dp = SEG_DP_W'(CURVE_PCT[1] - CURVE_PCT[0]);
    for (int k = CURVE_PTS - 1; k >= 1; k--) begin
      if (mv <= CURVE_MV[k]) begin
        s.m0 = CURVE_MV[k-1];
        s.dm = SEG_DM_W'(CURVE_MV[k] - CURVE_MV[k-1]);
        s.p0 = CURVE_PCT[k-1];
        s.dp = SEG_DP_W'(CURVE_PCT[k] - CURVE_PCT[k-1]);
      end
    end
    return s;
  endfunction

endpackage

FILE: rtl/bgma_ram.sv
module bgma_ram #(
  parameter int unsigned WIDTH = 12,
  parameter int unsigned DEPTH = 10,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

FILE: rtl/bgma_div.sv
module bgma_div #(
  parameter int unsigned DIVIDEND_W = 22,
  parameter int unsigned DIVISOR_W  = 12
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  den_q;
  logic [CNT_W-1:0]      cnt_q;
  logic                  busy_q;
  logic                  done_q;
  logic [DIVISOR_W:0]    rem_sh;
  logic [DIVISOR_W:0]    rem_sub;
  logic                  fits;

  assign rem_sh  = {rem_q, quo_q[DIVIDEND_W-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign fits    = rem_sh >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(DIVIDEND_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      den_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? rem_sub[DIVISOR_W-1:0] : rem_sh[DIVISOR_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

FILE: rtl/bgma_front.sv
module bgma_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           sense_present_i,
  input  logic           push_i,
  input  bgma_pkg::in_t  in_i,
  output logic           full_o,
  output logic           job_valid_o,
  output bgma_pkg::job_t job_o,
  input  logic           job_pop_i
);

  localparam int unsigned QDEPTH = 2;
  localparam int unsigned PTR_W  = 1;
  localparam int unsigned QCNT_W = 2;

  bgma_pkg::job_t    entry_q [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr_q;
  logic [PTR_W-1:0]  rd_ptr_q;
  logic [QCNT_W-1:0] cnt_q;
  logic              push_ok;
  logic              pop_ok;
  bgma_pkg::job_t    job_new;

  assign full_o      = cnt_q == QCNT_W'(QDEPTH);
  assign job_valid_o = cnt_q != '0;
  assign push_ok     = push_i && !full_o;
  assign pop_ok      = job_pop_i && job_valid_o;
  assign job_o       = entry_q[rd_ptr_q];

  assign job_new.sample   = in_i.adc_sample;
  assign job_new.charging = sense_present_i && !in_i.charge_pin_level;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_ok) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_ok) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      if (push_ok && !pop_ok) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_ok && !push_ok) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      entry_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

FILE: rtl/bgma_back.sv
module bgma_back #(
  parameter int unsigned RING_DEPTH = 10,
  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1),
  localparam int unsigned SUM_W = bgma_pkg::SAMPLE_W + CNT_W,
  localparam int unsigned DIV_W = (SUM_W > bgma_pkg::MV_NUM_W) ? SUM_W : bgma_pkg::MV_NUM_W,
  localparam int unsigned DVS_W = (CNT_W > bgma_pkg::SAMPLE_W) ? CNT_W : bgma_pkg::SAMPLE_W
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bgma_pkg::cfg_t                cfg_i,
  input  logic                          job_valid_i,
  input  bgma_pkg::job_t                job_i,
  output logic                          job_pop_o,
  output logic                          ram_we_o,
  output logic [IDX_W-1:0]              ram_waddr_o,
  output logic [bgma_pkg::SAMPLE_W-1:0] ram_wdata_o,
  output logic                          ram_re_o,
  output logic [IDX_W-1:0]              ram_raddr_o,
  input  logic [bgma_pkg::SAMPLE_W-1:0] ram_rdata_i,
  output logic                          div_start_o,
  output logic [DIV_W-1:0]              div_dividend_o,
  output logic [DVS_W-1:0]              div_divisor_o,
  input  logic                          div_done_i,
  input  logic [DIV_W-1:0]              div_quotient_i,
  input  logic                          pop_i,
  output logic                          empty_o,
  output bgma_pkg::out_t                out_o
);

  bgma_pkg::back_state_e state_q, state_d;

  bgma_pkg::job_t                job_q;
  logic [IDX_W-1:0]              wr_idx_q;
  logic [CNT_W-1:0]              fill_q;
  logic [CNT_W-1:0]              k_q;
  logic [SUM_W-1:0]              sum_q;
  logic [bgma_pkg::SAMPLE_W-1:0] avg_q;
  logic [bgma_pkg::MV_W-1:0]     mv_q;
  logic [bgma_pkg::PCT_W-1:0]    pct_q;
  logic [bgma_pkg::PCT_W-1:0]    p0_q;
  logic [DIV_W-1:0]              op_num_q;
  logic [DVS_W-1:0]              op_den_q;
  logic                          out_vld_q;
  bgma_pkg::out_t                out_q;
  logic                          out_load;
  bgma_pkg::seg_t                seg;
  logic [bgma_pkg::SAMPLE_W-1:0] avg_off;
  logic [bgma_pkg::SEG_DM_W-1:0] mv_off;

  assign seg     = bgma_pkg::curve_segment(mv_q);
  assign avg_off = avg_q - cfg_i.raw_empty;
  assign mv_off  = bgma_pkg::SEG_DM_W'(mv_q - seg.m0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bgma_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    job_pop_o   = 1'b0;
    ram_we_o    = 1'b0;
    ram_re_o    = 1'b0;
    div_start_o = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      bgma_pkg::ST_IDLE: begin
        if (job_valid_i) begin
          job_pop_o = 1'b1;
          state_d   = bgma_pkg::ST_WRITE;
        end
      end
      bgma_pkg::ST_WRITE: begin
        ram_we_o = 1'b1;
        state_d  = bgma_pkg::ST_SUM;
      end
      bgma_pkg::ST_SUM: begin
        ram_re_o = k_q < fill_q;
        if (k_q == fill_q) begin
          state_d = bgma_pkg::ST_AVG_START;
        end
      end
      bgma_pkg::ST_AVG_START: begin
        div_start_o = 1'b1;
        state_d     = bgma_pkg::ST_AVG_WAIT;
      end
      bgma_pkg::ST_AVG_WAIT: begin
        if (div_done_i) begin
          state_d = bgma_pkg::ST_MV_MAP;
        end
      end
      bgma_pkg::ST_MV_MAP: begin
        if (avg_q <= cfg_i.raw_empty || avg_q >= cfg_i.raw_full) begin
          state_d = bgma_pkg::ST_PCT_MAP;
        end else begin
          state_d = bgma_pkg::ST_MV_START;
        end
      end
      bgma_pkg::ST_MV_START: begin
        div_start_o = 1'b1;
        state_d     = bgma_pkg::ST_MV_WAIT;
      end
      bgma_pkg::ST_MV_WAIT: begin
        if (div_done_i) begin
          state_d = bgma_pkg::ST_PCT_MAP;
        end
      end
      bgma_pkg::ST_PCT_MAP: begin
        if (mv_q <= bgma_pkg::MV_EMPTY || mv_q > bgma_pkg::MV_FULL) begin
          state_d = bgma_pkg::ST_OUT;
        end else begin
          state_d = bgma_pkg::ST_PCT_START;
        end
      end
      bgma_pkg::ST_PCT_START: begin
        div_start_o = 1'b1;
        state_d     = bgma_pkg::ST_PCT_WAIT;
      end
      bgma_pkg::ST_PCT_WAIT: begin
        if (div_done_i) begin
          state_d = bgma_pkg::ST_OUT;
        end
      end
      bgma_pkg::ST_OUT: begin
        if (!out_vld_q || pop_i) begin
          out_load = 1'b1;
          state_d  = bgma_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bgma_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_idx_q  <= '0;
      fill_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (ram_we_o) begin
        wr_idx_q <= (wr_idx_q == IDX_W'(RING_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;
        if (fill_q < CNT_W'(RING_DEPTH)) begin
          fill_q <= fill_q + 1'b1;
        end
      end
      if (out_load) begin
        out_vld_q <= 1'b1;
      end else if (pop_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q <= job_i;
    end
    if (state_q == bgma_pkg::ST_WRITE) begin
      k_q   <= '0;
      sum_q <= '0;
    end
    if (state_q == bgma_pkg::ST_SUM) begin
      if (k_q != '0) begin
        sum_q <= sum_q + SUM_W'(ram_rdata_i);
      end
      if (k_q < fill_q) begin
        k_q <= k_q + 1'b1;
      end
    end
    if (state_q == bgma_pkg::ST_AVG_WAIT && div_done_i) begin
      avg_q <= div_quotient_i[bgma_pkg::SAMPLE_W-1:0];
    end
    if (state_q == bgma_pkg::ST_MV_MAP) begin
      if (avg_q <= cfg_i.raw_empty) begin
        mv_q <= bgma_pkg::MV_EMPTY;
      end else if (avg_q >= cfg_i.raw_full) begin
        mv_q <= bgma_pkg::MV_FULL;
      end else begin
        op_num_q <= DIV_W'(bgma_pkg::MV_NUM_W'(avg_off) * bgma_pkg::MV_NUM_W'(bgma_pkg::MV_SPAN));
        op_den_q <= DVS_W'(cfg_i.raw_full - cfg_i.raw_empty);
      end
    end
    if (state_q == bgma_pkg::ST_MV_WAIT && div_done_i) begin
      mv_q <= bgma_pkg::MV_EMPTY + bgma_pkg::MV_W'(div_quotient_i);
    end
    if (state_q == bgma_pkg::ST_PCT_MAP) begin
      if (mv_q <= bgma_pkg::MV_EMPTY) begin
        pct_q <= '0;
      end else if (mv_q > bgma_pkg::MV_FULL) begin
        pct_q <= bgma_pkg::PCT_FULL;
      end else begin
        op_num_q <= DIV_W'(bgma_pkg::SEG_NUM_W'(mv_off) * bgma_pkg::SEG_NUM_W'(seg.dp));
        op_den_q <= DVS_W'(seg.dm);
        p0_q     <= seg.p0;
      end
    end
    if (state_q == bgma_pkg::ST_PCT_WAIT && div_done_i) begin
      pct_q <= p0_q + bgma_pkg::PCT_W'(div_quotient_i);
    end
    if (out_load) begin
      out_q.average_raw        <= avg_q;
      out_q.battery_millivolts <= mv_q;
      out_q.charge_percent     <= pct_q;
      out_q.is_charging        <= job_q.charging;
    end
  end

  always_comb begin
    if (state_q == bgma_pkg::ST_AVG_START) begin
      div_dividend_o = DIV_W'(sum_q);
      div_divisor_o  = DVS_W'(fill_q);
    end else begin
      div_dividend_o = op_num_q;
      div_divisor_o  = op_den_q;
    end
  end

  assign ram_waddr_o = wr_idx_q;
  assign ram_wdata_o = job_q.sample;
  assign ram_raddr_o = k_q[IDX_W-1:0];
  assign empty_o     = !out_vld_q;
  assign out_o       = out_q;

  // A waiting result must not change until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !pop_i) |=> (out_vld_q && $stable(out_q)))
    else $error("waiting result changed before it was taken");

  // After a sample is stored, the fill count is between one and the ring depth.
  a_fill_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we_o |=> (fill_q != '0 && fill_q <= CNT_W'(RING_DEPTH)))
    else $error("fill count out of range after a ring write");

  // A loaded result carries a voltage and a percentage inside their ranges.
  a_result_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (out_q.battery_millivolts >= bgma_pkg::MV_EMPTY &&
                  out_q.battery_millivolts <= bgma_pkg::MV_FULL &&
                  out_q.charge_percent <= bgma_pkg::PCT_FULL))
    else $error("result voltage or percentage out of range");

  // The divider only finishes while the sequencer waits for it.
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done_i |-> (state_q == bgma_pkg::ST_AVG_WAIT || state_q == bgma_pkg::ST_MV_WAIT ||
                    state_q == bgma_pkg::ST_PCT_WAIT))
    else $error("divider finished outside a wait state");

endmodule

FILE: rtl/battery_gauge_moving_average_unit.sv
// Battery fuel gauge: each transaction carries one 12-bit ADC sample and the charge pin level,
// and yields the truncated mean of the last RING_DEPTH samples (fewer until the ring fills),
// the voltage mapped linearly between raw_empty and raw_full onto 3300 to 4200 mV, the LiPo
// state of charge interpolated on a 12-point curve, and the charging flag. A two-entry queue
// decouples the input from the sequencer, and a result register lets the next transaction
// enter while a result waits. The sequencer handles one transaction at a time: it stores the
// sample, sums the N stored samples, N being the fill count after its sample is stored, and
// divides. It skips the voltage division when the voltage clamps at 4200 mV, and both the
// voltage and the percentage divisions when it clamps at 3300 mV. The bit-serial divider is
// shared by the average, the voltage and the percentage, and the single ring read port sums
// one stored sample per cycle.
// The sample ring needs no clearing after reset, so transactions are taken right away.
module battery_gauge_moving_average_unit #(
  parameter int unsigned RING_DEPTH = 10
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push,
  output logic                           full,
  input  bgma_pkg::in_t                  in_data_i,
  output logic                           empty,
  input  logic                           pop,
  output bgma_pkg::out_t                 out_data_o,
  input  logic                           cfg_we_i,
  input  logic [bgma_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bgma_pkg::SAMPLE_W-1:0]  cfg_wdata_i
);

  localparam int unsigned IDX_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SUM_W = bgma_pkg::SAMPLE_W + CNT_W;
  localparam int unsigned DIV_W = (SUM_W > bgma_pkg::MV_NUM_W) ? SUM_W : bgma_pkg::MV_NUM_W;
  localparam int unsigned DVS_W = (CNT_W > bgma_pkg::SAMPLE_W) ? CNT_W : bgma_pkg::SAMPLE_W;

  bgma_pkg::cfg_t                cfg_q;
  logic                          job_valid;
  bgma_pkg::job_t                job;
  logic                          job_pop;
  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  logic [bgma_pkg::SAMPLE_W-1:0] ram_wdata;
  logic                          ram_re;
  logic [IDX_W-1:0]              ram_raddr;
  logic [bgma_pkg::SAMPLE_W-1:0] ram_rdata;
  logic                          div_start;
  logic [DIV_W-1:0]              div_dividend;
  logic [DVS_W-1:0]              div_divisor;
  logic                          div_done;
  logic [DIV_W-1:0]              div_quotient;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.raw_empty            <= bgma_pkg::RAW_EMPTY_RST;
      cfg_q.raw_full             <= bgma_pkg::RAW_FULL_RST;
      cfg_q.charge_sense_present <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bgma_pkg::CFG_RAW_EMPTY:    cfg_q.raw_empty            <= cfg_wdata_i;
        bgma_pkg::CFG_RAW_FULL:     cfg_q.raw_full             <= cfg_wdata_i;
        bgma_pkg::CFG_CHARGE_SENSE: cfg_q.charge_sense_present <= cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  bgma_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .sense_present_i (cfg_q.charge_sense_present),
    .push_i          (push),
    .in_i            (in_data_i),
    .full_o          (full),
    .job_valid_o     (job_valid),
    .job_o           (job),
    .job_pop_i       (job_pop)
  );

  bgma_ram #(
    .WIDTH (bgma_pkg::SAMPLE_W),
    .DEPTH (RING_DEPTH)
  ) u_ring (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bgma_div #(
    .DIVIDEND_W (DIV_W),
    .DIVISOR_W  (DVS_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quotient_o (div_quotient)
  );

  bgma_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .job_valid_i    (job_valid),
    .job_i          (job),
    .job_pop_o      (job_pop),
    .ram_we_o       (ram_we),
    .ram_waddr_o    (ram_waddr),
    .ram_wdata_o    (ram_wdata),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .div_start_o    (div_start),
    .div_dividend_o (div_dividend),
    .div_divisor_o  (div_divisor),
    .div_done_i     (div_done),
    .div_quotient_i (div_quotient),
    .pop_i          (pop),
    .empty_o        (empty),
    .out_o          (out_data_o)
  );

endmodule
